// File: design/vt4_pkg.sv
// Package for the 4x4 vertex transform: widths, vector and matrix types,
// register map and reset values of the matrix registers.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package vt4_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COMP_W    = 32;
	localparam int NUM_COMP  = 4;
	localparam int PROD_W    = 2 * COMP_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;
	localparam int REG_W     = 64;
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int PADDR_W   = REG_IDX_W + 3;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef comp_t [NUM_COMP-1:0] vec4_t;
	typedef vec4_t [NUM_COMP-1:0] mat_t;
	typedef logic [REG_W-1:0] reg64_t;

	localparam comp_t SAT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
	localparam comp_t SAT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

	localparam reg64_t REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
	};

endpackage

`default_nettype wire

// File: design/vt4_cfg.sv
// Matrix register file behind the APB-style configuration port.
// Holds eight 64-bit registers (two matrix entries each) and presents the matrix.
// Depends on vt4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vt4_cfg (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [vt4_pkg::PADDR_W-1:0] paddr,
	input  wire logic [vt4_pkg::REG_W-1:0]   pwdata,
	output logic      [vt4_pkg::REG_W-1:0]   prdata,
	output logic                          pready,
	output vt4_pkg::mat_t                 mat
);
	import vt4_pkg::*;

	reg64_t                regs_q [NUM_REGS];
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;
	assign prdata  = regs_q[reg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET[i];
			end
		end else if (wr_en) begin
			regs_q[reg_idx] <= pwdata;
		end
	end

	// Row r uses register 2r for columns 0 and 1, register 2r+1 for columns 2 and 3.
	always_comb begin
		for (int r = 0; r < NUM_COMP; r++) begin
			mat[r][0] = regs_q[2*r][COMP_W-1:0];
			mat[r][1] = regs_q[2*r][REG_W-1:COMP_W];
			mat[r][2] = regs_q[2*r+1][COMP_W-1:0];
			mat[r][3] = regs_q[2*r+1][REG_W-1:COMP_W];
		end
	end

endmodule

`default_nettype wire

// File: design/vt4_lane.sv
// One column lane: four products, a two-level registered adder tree, then
// the floor shift and saturation of the exact sum.
// Depends on vt4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vt4_lane (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire vt4_pkg::vec4_t vec,
	input  wire vt4_pkg::vec4_t col,
	output vt4_pkg::comp_t      result
);
	import vt4_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [NUM_COMP];
	logic signed [PAIR_W-1:0] pair_s2 [2];
	logic signed [SUM_W-1:0]  sum_s3;
	logic                     in_range;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NUM_COMP; j++) begin
				prod_s1[j] <= PROD_W'(vec[j]) * PROD_W'(col[j]);
			end
			pair_s2[0] <= {prod_s1[0][PROD_W-1], prod_s1[0]}
				+ {prod_s1[1][PROD_W-1], prod_s1[1]};
			pair_s2[1] <= {prod_s1[2][PROD_W-1], prod_s1[2]}
				+ {prod_s1[3][PROD_W-1], prod_s1[3]};
			sum_s3 <= {pair_s2[0][PAIR_W-1], pair_s2[0]}
				+ {pair_s2[1][PAIR_W-1], pair_s2[1]};
		end
	end

	// The shifted sum fits in 32 bits when all bits above its sign bit agree.
	assign in_range = (&sum_s3[SUM_W-1:FRAC_BITS+COMP_W-1])
		|| !(|sum_s3[SUM_W-1:FRAC_BITS+COMP_W-1]);

	always_comb begin
		if (in_range) begin
			result = sum_s3[FRAC_BITS+COMP_W-1:FRAC_BITS];
		end else if (sum_s3[SUM_W-1]) begin
			result = SAT_MIN;
		end else begin
			result = SAT_MAX;
		end
	end

endmodule

`default_nettype wire

// File: design/vertex_transform_4x4_top.sv
// Top level of the 4x4 vertex transform: configuration registers, four
// column lanes and the output stage that merges their results.
// Depends on vt4_pkg, vt4_cfg and vt4_lane.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries a row vector (in_x, in_y, in_z, in_w) in signed Q16.16
// and yields one result v_k = sum_j in_j * m[j][k], floor-shifted by 16 and
// saturated to 32 bits, with last_in copied to last_out. The block takes one
// request per clock while no result waits under out_stall, and returns it after
// one multiply stage, two adder stages and the output register. Sixteen 32x32
// multipliers, one per matrix entry in four column lanes, set that rate. The whole
// pipeline holds while a result waits under out_stall, so in_stall follows
// out_stall in the same cycle. The matrix resets to identity and should be written
// only while no request is in flight; no clearing pass runs after reset.
module vertex_transform_4x4_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire vt4_pkg::comp_t              in_x,
	input  wire vt4_pkg::comp_t              in_y,
	input  wire vt4_pkg::comp_t              in_z,
	input  wire vt4_pkg::comp_t              in_w,
	input  wire logic                        last_in,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output vt4_pkg::comp_t                   out_x,
	output vt4_pkg::comp_t                   out_y,
	output vt4_pkg::comp_t                   out_z,
	output vt4_pkg::comp_t                   out_w,
	output logic                             last_out,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [vt4_pkg::PADDR_W-1:0] paddr,
	input  wire logic [vt4_pkg::REG_W-1:0]   pwdata,
	output logic      [vt4_pkg::REG_W-1:0]   prdata,
	output logic                             pready
);
	import vt4_pkg::*;

	mat_t   mat;
	vec4_t  vec_in;
	vec4_t  cols [NUM_COMP];
	comp_t  lane_res [NUM_COMP];
	logic   en;

	logic   v_s1, v_s2, v_s3;
	logic   last_s1, last_s2, last_s3;
	logic   out_valid_q;
	logic   last_q;
	vec4_t  res_q;

	vt4_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mat     (mat)
	);

	assign vec_in = {in_w, in_z, in_y, in_x};

	always_comb begin
		for (int k = 0; k < NUM_COMP; k++) begin
			for (int j = 0; j < NUM_COMP; j++) begin
				cols[k][j] = mat[j][k];
			end
		end
	end

	for (genvar k = 0; k < NUM_COMP; k++) begin : g_lane
		vt4_lane u_lane (
			.clk    (clk),
			.en     (en),
			.vec    (vec_in),
			.col    (cols[k]),
			.result (lane_res[k])
		);
	end

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= last_in;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_q  <= last_s3;
			for (int k = 0; k < NUM_COMP; k++) begin
				res_q[k] <= lane_res[k];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = res_q[0];
	assign out_y     = res_q[1];
	assign out_z     = res_q[2];
	assign out_w     = res_q[3];
	assign last_out  = last_q;

endmodule

`default_nettype wire
